>>> rtl/dcrb_pkg.sv
// Package for the delta copy recipe builder: field widths, word layouts,
// command codes and the shared item, result and state types. No dependencies.
package dcrb_pkg;

  localparam int unsigned OffW   = 48;
  localparam int unsigned IdxW   = 32;
  localparam int unsigned SizeW  = 31;
  localparam int unsigned CountW = 32;

  // Stream word widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 112;

  // Result queue geometry.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef enum logic {
    CMD_ENTRY = 1'b0,
    CMD_END   = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e              command;
    logic [OffW-1:0]   file_offset;
    logic [IdxW-1:0]   block_index;
    logic [SizeW-1:0]  block_size;
  } item_t;

  typedef struct packed {
    logic [OffW-1:0]   space_before;
    logic              has_blocks;
    logic [IdxW-1:0]   first_block;
    logic [CountW-1:0] block_count;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [OffW-1:0]   position;
    logic [OffW-1:0]   pending_space;
    logic [IdxW-1:0]   pending_first;
    logic [CountW-1:0] pending_count;
    logic              pending_has_block;
    logic              any_match_seen;
  } state_t;

  // Up to two results are pushed into the queue per processed item.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

>>> rtl/delta_copy_recipe_builder.sv
// Delta copy recipe builder top level: input word register, recipe state,
// step logic and result queue. Depends on dcrb_pkg and dcrb_outq.
// An accepted word waits in the input register until the step fires and its
// result words enter the result queue. Throughput: one input word per cycle
// while the queue has room for two words; the end command yields two words
// when a literal tail is needed, which the four-word result queue absorbs.
// Reset clears the recipe state, file_size and the queue; no clearing pass.
module delta_copy_recipe_builder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: file_size write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dcrb_pkg::OffW-1:0]     cfg_data_i,
  // Input stream of match entries.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, lowest bit up: file_offset[47:0], block_index[79:48],
  // block_size[110:80], zero pad [111].
  input  logic [dcrb_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: command[0] (0 = match entry, 1 = end of list).
  input  logic                          s_axis_tuser,
  // Output stream of delta instructions.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata, lowest bit up: space_before[47:0], first_block[79:48],
  // block_count[111:80].
  output logic [dcrb_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: has_blocks[0].
  output logic                          m_axis_tuser,
  output logic                          m_axis_tlast
);

  // Always ready configuration register; the user must write it only while idle, the block does not check.
  logic [dcrb_pkg::OffW-1:0] file_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
    end else if (cfg_valid_i) begin
      file_size_q <= cfg_data_i;
    end
  end

  // Input word register. The step fires whenever the queue has room for the
  // two words the worst case produces, so the register drains every cycle in
  // steady state and a new word can land behind the one being processed.
  logic            in_valid_q;
  dcrb_pkg::item_t in_item_q;
  dcrb_pkg::item_t in_item;
  logic            fire;
  logic            room2;

  assign in_item.command     = dcrb_pkg::cmd_e'(s_axis_tuser);
  assign in_item.file_offset = s_axis_tdata[47:0];
  assign in_item.block_index = s_axis_tdata[79:48];
  assign in_item.block_size  = s_axis_tdata[110:80];

  assign fire          = in_valid_q && room2;
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= in_item;
    end
  end

  // Recipe state and the step logic that advances it by one word.
  dcrb_pkg::state_t st_q, st_d;
  dcrb_pkg::push_t  push;

  always_comb begin
    logic                        gap;
    logic [dcrb_pkg::OffW-1:0]   base;
    logic [dcrb_pkg::OffW:0]     sum;
    logic [dcrb_pkg::IdxW-1:0]   next_idx;
    logic                        tail;

    st_d     = st_q;
    push     = '0;
    gap      = in_item_q.file_offset > st_q.position;
    base     = gap ? in_item_q.file_offset : st_q.position;
    sum      = {1'b0, base} + {{(dcrb_pkg::OffW + 1 - dcrb_pkg::SizeW){1'b0}},
                               in_item_q.block_size};
    next_idx = st_q.pending_first + st_q.pending_count;
    tail     = st_q.position < file_size_q;

    if (fire) begin
      if (in_item_q.command == dcrb_pkg::CMD_ENTRY) begin
        st_d.any_match_seen = 1'b1;
        // A match behind the current position is dropped.
        if (in_item_q.file_offset >= st_q.position) begin
          if (gap) begin
            // Flush whatever is pending, then open an instruction holding the gap.
            if (st_q.pending_space != '0 || st_q.pending_has_block) begin
              push.cnt = 2'd1;
              push.r0  = '{space_before: st_q.pending_space,
                            has_blocks:   st_q.pending_has_block,
                            first_block:  st_q.pending_first,
                            block_count:  st_q.pending_count,
                            last:         1'b0};
            end
            st_d.pending_space     = in_item_q.file_offset - st_q.position;
            st_d.pending_has_block = 1'b0;
            st_d.pending_first     = '0;
            st_d.pending_count     = '0;
          end else if (st_q.pending_has_block && in_item_q.block_index != next_idx) begin
            // The block does not continue the run, so the run goes out.
            push.cnt = 2'd1;
            push.r0  = '{space_before: st_q.pending_space,
                          has_blocks:   1'b1,
                          first_block:  st_q.pending_first,
                          block_count:  st_q.pending_count,
                          last:         1'b0};
            st_d.pending_space     = '0;
            st_d.pending_has_block = 1'b0;
            st_d.pending_first     = '0;
            st_d.pending_count     = '0;
          end

          if (!st_d.pending_has_block) begin
            st_d.pending_has_block = 1'b1;
            st_d.pending_first     = in_item_q.block_index;
            st_d.pending_count     = dcrb_pkg::CountW'(1);
          end else if (st_d.pending_count != '1) begin
            st_d.pending_count = st_d.pending_count + dcrb_pkg::CountW'(1);
          end

          // Position saturates at the top of the offset range.
          st_d.position = sum[dcrb_pkg::OffW] ? '1 : sum[dcrb_pkg::OffW-1:0];
        end
      end else begin
        if (!st_q.any_match_seen) begin
          push.cnt = 2'd1;
          push.r0  = '{space_before: file_size_q, has_blocks: 1'b0,
                        first_block: '0, block_count: '0, last: 1'b1};
        end else begin
          push.cnt = tail ? 2'd2 : 2'd1;
          push.r0  = '{space_before: st_q.pending_space,
                        has_blocks:   st_q.pending_has_block,
                        first_block:  st_q.pending_has_block ? st_q.pending_first : '0,
                        block_count:  st_q.pending_has_block ? st_q.pending_count : '0,
                        last:         !tail};
          push.r1  = '{space_before: file_size_q - st_q.position, has_blocks: 1'b0,
                        first_block: '0, block_count: '0, last: 1'b1};
        end
        // The end command leaves the builder as it was after reset.
        st_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  // Result queue and output packing.
  dcrb_pkg::result_t out_word;

  dcrb_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room2_o     (room2),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (out_word)
  );

  assign m_axis_tdata = {out_word.block_count, out_word.first_block, out_word.space_before};
  assign m_axis_tuser = out_word.has_blocks;
  assign m_axis_tlast = out_word.last;

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_item_q.command == dcrb_pkg::CMD_END) |=>
      (!st_q.any_match_seen && st_q.position == '0 && !st_q.pending_has_block))
    else $error("end command did not return the builder to its idle state");

  a_empty_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.pending_has_block |-> (st_q.pending_count == '0 && st_q.pending_first == '0))
    else $error("empty pending run carries block data");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !fire) |=> (in_valid_q && $stable(in_item_q)))
    else $error("stalled input word was lost or changed");

  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && in_valid_q) |-> fire)
    else $error("input taken while the held word is not processed");
`endif

endmodule

>>> rtl/dcrb_outq.sv
// Four-word result queue for the delta copy recipe builder. Takes up to two
// words per cycle and hands one word per cycle to the output stream while it
// is ready. Depends on dcrb_pkg.
module dcrb_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dcrb_pkg::push_t  push_i,
  output logic             room2_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dcrb_pkg::result_t out_word_o
);

  dcrb_pkg::result_t entries_q [dcrb_pkg::QDepth];
  logic [dcrb_pkg::QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [dcrb_pkg::QCntW-1:0] cnt_q, cnt_d;
  logic                       pop;
  logic [dcrb_pkg::QPtrW-1:0] wr_ptr_nxt;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = entries_q[rd_ptr_q];
  // Room for two words regardless of whether a word leaves this cycle.
  assign room2_o     = (cnt_q <= dcrb_pkg::QCntW'(dcrb_pkg::QDepth - 2));
  assign wr_ptr_nxt  = wr_ptr_q + dcrb_pkg::QPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + dcrb_pkg::QPtrW'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + dcrb_pkg::QPtrW'(pop);
    cnt_d    = cnt_q + dcrb_pkg::QCntW'(push_i.cnt) - dcrb_pkg::QCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      entries_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      entries_q[wr_ptr_nxt] <= push_i.r1;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= dcrb_pkg::QCntW'(dcrb_pkg::QDepth))
    else $error("result queue overfilled");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != dcrb_pkg::QCntW'(dcrb_pkg::QDepth)) |->
      (dcrb_pkg::QPtrW'(wr_ptr_q - rd_ptr_q) == dcrb_pkg::QPtrW'(cnt_q)))
    else $error("queue pointers disagree with fill count");
`endif

endmodule
